// File: rtl/spd_pkg.sv
// Package for the sensor packet deframer: word types, result kinds and constants.
// Used by spd_eval, spd_out_fifo and sensor_packet_deframer. No dependencies.
package spd_pkg;

    // Bytes held in the window ahead of the newest byte.
    localparam int unsigned WIN_KEEP = 18;
    localparam int unsigned WIN_IDX_W = 5;
    localparam logic [WIN_IDX_W-1:0] WIN_FULL = WIN_IDX_W'(WIN_KEEP);

    localparam int unsigned SKIP_W = 2;
    localparam logic [SKIP_W-1:0] MAX_SKIPS = 2'd3;

    localparam logic [15:0] CAPACITY_RESET = 16'd20480;
    localparam logic [15:0] COUNT_QUIRK = 16'd256;

    localparam logic [7:0] BATT_MARK_HI = 8'hFF;
    localparam logic [7:0] BATT_MARK_LO = 8'h00;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_BATTERY = 2'd1;
    localparam logic [1:0] KIND_FRAME_END = 2'd2;

    // Output queue depth; one processed byte can push two words.
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PTR_W = 2;
    localparam int unsigned FIFO_CNT_W = 3;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       frame_last;
    } in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] value;
        logic [15:0] index;
        logic        run_last;
    } out_t;

    // Words produced by one processed byte, first word in r0.
    typedef struct packed {
        logic [1:0] cnt;
        out_t       r0;
        out_t       r1;
    } res_t;

endpackage

// File: rtl/spd_eval.sv
// Input register, sliding window and per-byte evaluation of the deframer.
// Depends on spd_pkg for the word types, result kinds and constants.
module spd_eval (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  spd_pkg::in_t    in_data,
    input  logic            space_ok,
    input  logic [15:0]     capacity,
    output spd_pkg::res_t   res
);

    logic                           in_vld_reg;
    spd_pkg::in_t                   in_reg;
    logic                           proc;

    logic [7:0]                     win_reg [spd_pkg::WIN_KEEP];
    logic [7:0]                     win_next [spd_pkg::WIN_KEEP];
    logic [7:0]                     wb [spd_pkg::WIN_KEEP+1];

    logic [spd_pkg::WIN_IDX_W-1:0]  fill_reg, fill_next;
    logic [15:0]                    count_reg, count_next;
    logic [7:0]                     prev_reg, prev_next;
    logic [spd_pkg::SKIP_W-1:0]     skip_reg, skip_next;
    logic                           full_reg, full_next;

    logic [15:0]                    count_eval;
    logic                           seq;
    logic                           battery;
    logic                           test_cap;
    logic [1:0]                     n;
    spd_pkg::out_t                  word;

    assign proc = in_vld_reg && space_ok;
    assign in_ready = !in_vld_reg || proc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_reg <= in_data;
        end
    end

    // Full window: the 18 stored bytes followed by the byte being processed.
    always_comb
    begin
        for (int i = 0; i < spd_pkg::WIN_KEEP; i++)
        begin
            wb[i] = win_reg[i];
        end
        wb[spd_pkg::WIN_KEEP] = in_reg.byte_value;
    end

    // Seven headers three bytes apart, each one more than the last.
    always_comb
    begin
        seq = 1'b1;
        for (int k = 1; k <= 6; k++)
        begin
            if (wb[3*k] != wb[3*k-3] + 8'd1)
            begin
                seq = 1'b0;
            end
        end
    end

    assign battery = (wb[0] == spd_pkg::BATT_MARK_HI) && (wb[1] == spd_pkg::BATT_MARK_LO)
                  && (wb[2] != spd_pkg::BATT_MARK_LO) && (wb[3] != spd_pkg::BATT_MARK_LO)
                  && (wb[4] == spd_pkg::BATT_MARK_LO) && (wb[5] == spd_pkg::BATT_MARK_HI);

    // The count is bumped by the pending skips when it sits exactly at 256.
    assign count_eval = (count_reg == spd_pkg::COUNT_QUIRK)
                      ? count_reg + {14'd0, skip_reg} : count_reg;

    always_comb
    begin
        for (int i = 0; i < spd_pkg::WIN_KEEP; i++)
        begin
            win_next[i] = win_reg[i];
        end
        fill_next  = fill_reg;
        count_next = count_reg;
        prev_next  = prev_reg;
        skip_next  = skip_reg;
        full_next  = full_reg;
        test_cap   = 1'b1;
        n          = 2'd0;
        word       = '0;
        res        = '0;

        if (proc)
        begin
            for (int i = 0; i < spd_pkg::WIN_KEEP - 1; i++)
            begin
                win_next[i] = win_reg[i+1];
            end
            win_next[spd_pkg::WIN_KEEP-1] = in_reg.byte_value;

            if (fill_reg < spd_pkg::WIN_FULL)
            begin
                fill_next = fill_reg + 5'd1;
            end
            else if (!full_reg)
            begin
                count_next = count_eval;
                if (seq)
                begin
                    if ((wb[0] != prev_reg + 8'd1) && (count_eval != 16'd0)
                        && (skip_reg < spd_pkg::MAX_SKIPS))
                    begin
                        skip_next = skip_reg + 2'd1;
                        test_cap  = 1'b0;
                    end
                    else
                    begin
                        word.kind  = spd_pkg::KIND_SAMPLE;
                        word.value = {wb[2], wb[1]};
                        word.index = count_eval;
                        res.r0     = word;
                        n          = 2'd1;
                        count_next = count_eval + 16'd1;
                        prev_next  = wb[0];
                        skip_next  = '0;
                    end
                end
                else if (battery)
                begin
                    word.kind  = spd_pkg::KIND_BATTERY;
                    word.value = {wb[3], wb[2]};
                    word.index = 16'd0;
                    res.r0     = word;
                    n          = 2'd1;
                end
                if (test_cap && (count_next >= capacity))
                begin
                    full_next = 1'b1;
                end
            end

            if (in_reg.frame_last)
            begin
                word.kind     = spd_pkg::KIND_FRAME_END;
                word.value    = count_next;
                word.index    = 16'd0;
                word.run_last = 1'b1;
                if (n == 2'd0)
                begin
                    res.r0 = word;
                end
                else
                begin
                    res.r1 = word;
                end
                n          = n + 2'd1;
                fill_next  = '0;
                count_next = '0;
                prev_next  = '0;
                skip_next  = '0;
                full_next  = 1'b0;
            end
            else if (n == 2'd1)
            begin
                res.r0.run_last = 1'b1;
            end
            res.cnt = n;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < spd_pkg::WIN_KEEP; i++)
            begin
                win_reg[i] <= '0;
            end
            fill_reg  <= '0;
            count_reg <= '0;
            prev_reg  <= '0;
            skip_reg  <= '0;
            full_reg  <= 1'b0;
        end
        else
        begin
            win_reg   <= win_next;
            fill_reg  <= fill_next;
            count_reg <= count_next;
            prev_reg  <= prev_next;
            skip_reg  <= skip_next;
            full_reg  <= full_next;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= spd_pkg::WIN_FULL)
        else $error("window fill level beyond the window size");

    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && in_reg.frame_last) |=> (fill_reg == '0 && count_reg == '0 && !full_reg))
        else $error("frame state not cleared after the last byte");

    a_end_word: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && in_reg.frame_last) |-> (res.cnt != 2'd0))
        else $error("last byte of a frame produced no frame end word");

    a_no_eval_short: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && fill_reg < spd_pkg::WIN_FULL && !in_reg.frame_last) |-> (res.cnt == 2'd0))
        else $error("word produced before the window was full");

endmodule

// File: rtl/spd_out_fifo.sv
// Four-word output queue that takes up to two words per cycle and hands out one.
// Depends on spd_pkg for the word and result types.
module spd_out_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  spd_pkg::res_t   res,
    output logic            space_ok,
    output logic            out_valid,
    input  logic            out_ready,
    output spd_pkg::out_t   out_data
);

    spd_pkg::out_t                   mem [spd_pkg::FIFO_DEPTH];
    logic [spd_pkg::FIFO_PTR_W-1:0]  wr_reg, wr_next;
    logic [spd_pkg::FIFO_PTR_W-1:0]  rd_reg, rd_next;
    logic [spd_pkg::FIFO_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                            pop;

    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem[rd_reg];
    assign pop       = out_valid && out_ready;
    // Room for the two words that the next byte may push.
    assign space_ok  = (cnt_reg <= spd_pkg::FIFO_CNT_W'(spd_pkg::FIFO_DEPTH - 2));

    assign wr_next  = wr_reg + spd_pkg::FIFO_PTR_W'(res.cnt);
    assign rd_next  = rd_reg + spd_pkg::FIFO_PTR_W'(pop);
    assign cnt_next = cnt_reg + spd_pkg::FIFO_CNT_W'(res.cnt)
                    - spd_pkg::FIFO_CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (res.cnt != 2'd0)
        begin
            mem[wr_reg] <= res.r0;
        end
        if (res.cnt == 2'd2)
        begin
            mem[wr_reg + spd_pkg::FIFO_PTR_W'(1)] <= res.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (res.cnt != 2'd0) |-> (cnt_reg <= spd_pkg::FIFO_CNT_W'(spd_pkg::FIFO_DEPTH - 2)))
        else $error("words pushed without room in the output queue");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= spd_pkg::FIFO_CNT_W'(spd_pkg::FIFO_DEPTH))
        else $error("output queue count beyond its depth");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg[spd_pkg::FIFO_PTR_W-1:0] == wr_reg - rd_reg)
        else $error("queue pointers disagree with the count");

endmodule

// File: rtl/sensor_packet_deframer.sv
// Top level of the sensor packet deframer, built on spd_pkg, spd_eval and spd_out_fifo.
// An accepted byte waits in the input register until its words are written into the queue.
// Throughput: one byte per cycle while the four-word output queue holds two words or
// fewer; a frame-end byte can push two words, and the input stalls while three or four wait.
// Reset (rst_n, asynchronous, active low) clears the window, the frame state and the
// queue, and sets the sample capacity to 20480.
module sensor_packet_deframer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  spd_pkg::in_t    in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output spd_pkg::out_t   out_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [15:0]     cfg_data
);

    logic [15:0]    capacity_reg;
    logic           space_ok;
    spd_pkg::res_t  res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= spd_pkg::CAPACITY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            capacity_reg <= cfg_data;
        end
    end

    spd_eval u_eval (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .space_ok (space_ok),
        .capacity (capacity_reg),
        .res      (res)
    );

    spd_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .space_ok  (space_ok),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
